/* src/szt_pkg.sv */
// Shared constants, register codes and types for the scale zero tracker.
package szt_pkg;

  localparam int SAMPLE_BITS_DEF = 24;

  localparam int COUNT_BITS = 16;
  localparam int RANGE_BITS = 23;
  localparam int CFG_DATA_BITS = 23;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_POWER_WAIT       = 3'd0,
    REG_POWER_ZERO_RANGE = 3'd1,
    REG_HAND_ZERO_RANGE  = 3'd2,
    REG_TRACE_PERIOD     = 3'd3,
    REG_TRACE_RANGE      = 3'd4,
    REG_TRACE_STEP       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] power_wait;
    logic [RANGE_BITS-1:0] power_zero_range;
    logic [RANGE_BITS-1:0] hand_zero_range;
    logic [COUNT_BITS-1:0] trace_period;
    logic [RANGE_BITS-1:0] trace_range;
    logic [RANGE_BITS-1:0] trace_step;
  } cfg_t;

  typedef struct packed {
    logic waiting;
    logic power_on;
  } status_t;

endpackage

/* src/szt_cfg.sv */
// Configuration register file of the scale zero tracker.
module szt_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [szt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [szt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output szt_pkg::cfg_t                        cfg
);
  import szt_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POWER_WAIT:       regs.power_wait       <= cfg_data[COUNT_BITS-1:0];
        REG_POWER_ZERO_RANGE: regs.power_zero_range <= cfg_data[RANGE_BITS-1:0];
        REG_HAND_ZERO_RANGE:  regs.hand_zero_range  <= cfg_data[RANGE_BITS-1:0];
        REG_TRACE_PERIOD:     regs.trace_period     <= cfg_data[COUNT_BITS-1:0];
        REG_TRACE_RANGE:      regs.trace_range      <= cfg_data[RANGE_BITS-1:0];
        REG_TRACE_STEP:       regs.trace_step       <= cfg_data[RANGE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

/* src/szt_update.sv */
// Zero tracking state and the per-sample update of zero, history and net value.
module szt_update #(
  parameter int SAMPLE_BITS = szt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   zero_request,
  input  szt_pkg::cfg_t          cfg,
  output logic [SAMPLE_BITS:0]   net,
  output szt_pkg::status_t       status
);
  import szt_pkg::*;

  // Working width holds every difference of two samples and every range register.
  localparam int CW = (SAMPLE_BITS + 1 > RANGE_BITS) ? SAMPLE_BITS + 1 : RANGE_BITS;
  localparam int W  = CW + 1;

  logic [COUNT_BITS:0]          power_count, power_count_next;
  logic [COUNT_BITS-1:0]        trace_count, trace_count_next;
  logic signed [SAMPLE_BITS-1:0] tracked_zero, tracked_zero_next;
  logic signed [SAMPLE_BITS-1:0] point_first, point_first_next;
  logic signed [SAMPLE_BITS-1:0] point_mid, point_mid_next;
  logic signed [SAMPLE_BITS-1:0] point_last, point_last_next;

  function automatic logic signed [W-1:0] absw(input logic signed [W-1:0] x);
    return x[W-1] ? -x : x;
  endfunction

  function automatic logic signed [W-1:0] sx(input logic signed [SAMPLE_BITS-1:0] x);
    return W'(x);
  endfunction

  function automatic logic signed [W-1:0] zx(input logic [RANGE_BITS-1:0] x);
    return $signed({{(W - RANGE_BITS){1'b0}}, x});
  endfunction

  logic [COUNT_BITS:0] wait_ext, tc_inc;
  logic waiting, power_on, hand_ok, fire, in_band, power_ok;
  logic signed [W-1:0] s_w, d_hand, e_first, e_mid, e_last, stp_w, rng_w, net_w;
  logic signed [W-1:0] z1_w, z2_w, zt_w, zp_w;
  logic signed [SAMPLE_BITS-1:0] z1;

  always_comb begin
    wait_ext = {1'b0, cfg.power_wait};
    waiting  = power_count < wait_ext;
    power_on = power_count == wait_ext;
    s_w      = sx($signed(sample));
    stp_w    = zx(cfg.trace_step);
    rng_w    = zx(cfg.trace_range);

    // Power-on zero candidate.
    power_ok = absw(s_w) <= zx(cfg.power_zero_range);
    zp_w     = power_ok ? s_w : sx(tracked_zero);

    // A manual request is applied before tracking on the same sample.
    d_hand  = s_w - sx(tracked_zero);
    hand_ok = zero_request && (absw(d_hand) <= zx(cfg.hand_zero_range));
    z1      = hand_ok ? $signed(sample) : tracked_zero;
    z1_w    = sx(z1);

    tc_inc = {1'b0, trace_count} + 1'b1;
    fire   = (cfg.trace_period != '0) && (tc_inc >= {1'b0, cfg.trace_period});

    // Deviations of the shifted history from the zero.
    e_first = sx(point_mid) - z1_w;
    e_mid   = sx(point_last) - z1_w;
    e_last  = s_w - z1_w;
    in_band = (absw(e_first) < rng_w) && (absw(e_mid) < rng_w) && (absw(e_last) < rng_w);

    if (absw(e_mid) <= stp_w) begin
      z2_w = sx(point_last);
    end else if (!e_mid[W-1]) begin
      z2_w = z1_w + stp_w;
    end else begin
      z2_w = z1_w - stp_w;
    end
    zt_w = (fire && in_band) ? z2_w : z1_w;

    power_count_next  = power_count;
    trace_count_next  = trace_count;
    tracked_zero_next = tracked_zero;
    point_first_next  = point_first;
    point_mid_next    = point_mid;
    point_last_next   = point_last;
    net_w             = '0;

    priority if (waiting) begin
      power_count_next = power_count + 1'b1;
    end else if (power_on) begin
      power_count_next  = power_count + 1'b1;
      tracked_zero_next = zp_w[SAMPLE_BITS-1:0];
      point_first_next  = $signed(sample);
      point_mid_next    = $signed(sample);
      point_last_next   = $signed(sample);
      trace_count_next  = '0;
      net_w             = s_w - zp_w;
    end else begin
      tracked_zero_next = zt_w[SAMPLE_BITS-1:0];
      net_w             = s_w - zt_w;
      if (cfg.trace_period == '0 || fire) begin
        trace_count_next = '0;
      end else begin
        trace_count_next = tc_inc[COUNT_BITS-1:0];
      end
      if (fire) begin
        point_first_next = point_mid;
        point_mid_next   = point_last;
        point_last_next  = $signed(sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_count  <= '0;
      trace_count  <= '0;
      tracked_zero <= '0;
      point_first  <= '0;
      point_mid    <= '0;
      point_last   <= '0;
    end else if (accept) begin
      power_count  <= power_count_next;
      trace_count  <= trace_count_next;
      tracked_zero <= tracked_zero_next;
      point_first  <= point_first_next;
      point_mid    <= point_mid_next;
      point_last   <= point_last_next;
    end
  end

  assign net             = net_w[SAMPLE_BITS:0];
  assign status.waiting  = waiting;
  assign status.power_on = power_on;

endmodule

/* src/scale_zero_tracking.sv */
// Weighing-scale zero tracker: one net value per load-cell sample.
//
// Samples enter on the sample channel (sample_valid, sample_stall, sample,
// zero_request); results leave on the net channel (net_valid, net_stall,
// net_value). A transaction completes when valid is high and stall is low.
// Configuration registers are written via cfg_write, cfg_index, cfg_data;
// the user must write them only while no sample is in flight (unenforced).
//
// Each accepted sample updates the zero, the tracking history and the net
// value in the same cycle; the result sits in the output register on the
// next cycle, and one sample can be taken every cycle while no waiting
// result is stalled. The rate is set by the update loop through the
// tracked zero, which the next sample depends on.
//
// Reset (rst, synchronous) clears every register but net_value, including the tracked zero and the
// history, and empties the output register. While the receiver stalls a
// waiting result, the output register holds it and sample_stall is raised;
// when the result is taken, a new sample may be accepted in the same cycle.
module scale_zero_tracking #(
  parameter int SAMPLE_BITS = szt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [szt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [szt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic                               zero_request,
  output logic                               net_valid,
  input  logic                               net_stall,
  output logic [SAMPLE_BITS:0]               net_value
);
  import szt_pkg::*;

  cfg_t                 cfg;
  status_t              status;
  logic                 accept;
  logic [SAMPLE_BITS:0] net;

  szt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  szt_update #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample       (sample),
    .zero_request (zero_request),
    .cfg          (cfg),
    .net          (net),
    .status       (status)
  );

  assign sample_stall = net_valid && net_stall;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      net_valid <= 1'b0;
    end else if (accept) begin
      net_valid <= 1'b1;
    end else if (!net_stall) begin
      net_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      net_value <= net;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !net_valid)
    else $error("output register not empty after reset");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> net_valid)
    else $error("accepted sample produced no result");

  a_wait_zero: assert property (@(posedge clk) disable iff (rst)
    accept && status.waiting |=> net_value == '0)
    else $error("nonzero net value during power-on wait");

  a_wait_excl: assert property (@(posedge clk) disable iff (rst)
    !(status.waiting && status.power_on))
    else $error("power-on wait and power-on sample at once");

endmodule
